// ===== rtl/core/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared codes, result type and literal tables of the JSON byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int POS_W = 24;

  // lexer phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_LIT_T = 4'd1;
  localparam logic [3:0] PH_LIT_F = 4'd2;
  localparam logic [3:0] PH_LIT_N = 4'd3;
  localparam logic [3:0] PH_STR   = 4'd4;
  localparam logic [3:0] PH_ESC   = 4'd5;
  localparam logic [3:0] PH_HEX   = 4'd6;
  localparam logic [3:0] PH_SIGN  = 4'd7;
  localparam logic [3:0] PH_ZERO  = 4'd8;
  localparam logic [3:0] PH_INT   = 4'd9;
  localparam logic [3:0] PH_DOT   = 4'd10;
  localparam logic [3:0] PH_FRAC  = 4'd11;
  localparam logic [3:0] PH_E     = 4'd12;
  localparam logic [3:0] PH_ESIGN = 4'd13;
  localparam logic [3:0] PH_EXP   = 4'd14;

  // result kinds
  localparam logic [1:0] RK_CONTENT = 2'd0;
  localparam logic [1:0] RK_TOKEN   = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;
  localparam logic [1:0] RK_END     = 2'd3;

  // token kinds
  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_LBRACK = 4'd2;
  localparam logic [3:0] TK_RBRACK = 4'd3;
  localparam logic [3:0] TK_COMMA  = 4'd4;
  localparam logic [3:0] TK_COLON  = 4'd5;
  localparam logic [3:0] TK_STRING = 4'd6;
  localparam logic [3:0] TK_NUMBER = 4'd7;
  localparam logic [3:0] TK_TRUE   = 4'd8;

  // error codes
  localparam logic [3:0] ER_BAD_TRUE   = 4'd0;
  localparam logic [3:0] ER_UNEXPECTED = 4'd3;
  localparam logic [3:0] ER_NUM_DIGIT  = 4'd4;
  localparam logic [3:0] ER_FRAC_DIGIT = 4'd5;
  localparam logic [3:0] ER_EXP_DIGIT  = 4'd6;
  localparam logic [3:0] ER_EOF_ESC    = 4'd7;
  localparam logic [3:0] ER_BAD_ESC    = 4'd8;
  localparam logic [3:0] ER_BAD_HEX    = 4'd9;
  localparam logic [3:0] ER_CTRL_CHAR  = 4'd10;
  localparam logic [3:0] ER_OPEN_STR   = 4'd11;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       tok;
    logic [7:0]       data;
    logic [3:0]       err;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
  } res_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [3:0] tok,
                                  input logic [7:0] data, input logic [3:0] err,
                                  input logic [POS_W-1:0] line,
                                  input logic [POS_W-1:0] col);
    res_t r;
    r.kind = kind;
    r.tok  = tok;
    r.data = data;
    r.err  = err;
    r.line = line;
    r.col  = col;
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] idx);
    return (idx == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [7:0] c;
    case ({idx, pos})
      {2'd0, 3'd0}: c = "t";
      {2'd0, 3'd1}: c = "r";
      {2'd0, 3'd2}: c = "u";
      {2'd0, 3'd3}: c = "e";
      {2'd1, 3'd0}: c = "f";
      {2'd1, 3'd1}: c = "a";
      {2'd1, 3'd2}: c = "l";
      {2'd1, 3'd3}: c = "s";
      {2'd1, 3'd4}: c = "e";
      {2'd2, 3'd0}: c = "n";
      {2'd2, 3'd1}: c = "u";
      {2'd2, 3'd2}: c = "l";
      {2'd2, 3'd3}: c = "l";
      default:      c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/jbt_lexer.sv =====
// ----------------------------------------------------------------------------
// jbt_lexer
// Lexer state and the single-pass step logic: one byte in, up to four results.
// ----------------------------------------------------------------------------
module jbt_lexer #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    step,
  input  logic [7:0]                              text_byte,
  input  logic                                    doc_start,
  input  logic                                    doc_end,
  output jbt_pkg::res_t [jbt_pkg::MAX_RES-1:0]    res,
  output logic [2:0]                              res_cnt
);

  logic [3:0]             phase, phase_next;
  logic [LINE_BITS-1:0]   line_cnt, line_cnt_next, start_line, start_line_next;
  logic [COLUMN_BITS-1:0] col_cnt, col_cnt_next, start_col, start_col_next;
  logic [15:0]            hex_acc, hex_acc_next;
  logic [2:0]             hex_seen, hex_seen_next;
  logic [2:0]             lit_prog, lit_prog_next;
  logic                   halted, halted_next;

  function automatic logic [jbt_pkg::POS_W-1:0] lpos(input logic [LINE_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[jbt_pkg::POS_W-1:0];
  endfunction

  function automatic logic [jbt_pkg::POS_W-1:0] cpos(input logic [COLUMN_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[jbt_pkg::POS_W-1:0];
  endfunction

  function automatic logic [LINE_BITS-1:0] bump_line(input logic [LINE_BITS-1:0] v,
                                                     input logic [7:0] b);
    return (b == 8'h0A && v != '1) ? v + 1'b1 : v;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] bump_col(input logic [COLUMN_BITS-1:0] v,
                                                      input logic [7:0] b);
    logic [COLUMN_BITS-1:0] r;
    if (b == 8'h0A) r = COLUMN_BITS'(1);
    else if (v != '1) r = v + 1'b1;
    else r = v;
    return r;
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [2:0] n;
    logic       do_idle;
    logic [1:0] li;
    logic [3:0] d;
    logic [3:0] tk;
    logic       punct;
    logic [7:0] ev;
    logic       ev_ok;
    b = text_byte;
    n = 3'd0;
    do_idle = 1'b0;
    li = 2'd0;
    d = 4'd0;
    tk = jbt_pkg::TK_LBRACE;
    punct = 1'b0;
    ev = 8'd0;
    ev_ok = 1'b1;
    res = '0;
    phase_next = phase;
    line_cnt_next = line_cnt;
    col_cnt_next = col_cnt;
    start_line_next = start_line;
    start_col_next = start_col;
    hex_acc_next = hex_acc;
    hex_seen_next = hex_seen;
    lit_prog_next = lit_prog;
    halted_next = halted;

    if (doc_start) begin
      phase_next = jbt_pkg::PH_IDLE;
      line_cnt_next = LINE_BITS'(1);
      col_cnt_next = COLUMN_BITS'(1);
      start_line_next = LINE_BITS'(1);
      start_col_next = COLUMN_BITS'(1);
      hex_acc_next = '0;
      hex_seen_next = '0;
      lit_prog_next = '0;
      halted_next = 1'b0;
    end

    if (!halted_next) begin
      case (phase_next)
        jbt_pkg::PH_LIT_T, jbt_pkg::PH_LIT_F, jbt_pkg::PH_LIT_N: begin
          li = 2'(phase_next - jbt_pkg::PH_LIT_T);
          if (lit_prog_next < jbt_pkg::lit_len(li) &&
              b == jbt_pkg::lit_char(li, lit_prog_next)) begin
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            lit_prog_next = lit_prog_next + 3'd1;
            if (lit_prog_next >= jbt_pkg::lit_len(li)) begin
              res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_TOKEN,
                jbt_pkg::TK_TRUE + 4'(li), 8'd0, 4'd0,
                lpos(start_line_next), cpos(start_col_next));
              n = n + 3'd1;
              lit_prog_next = 3'd0;
              phase_next = jbt_pkg::PH_IDLE;
            end
          end else begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_BAD_TRUE + 4'(li), lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end
        end
        jbt_pkg::PH_STR: begin
          if (b == 8'h22) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_TOKEN, jbt_pkg::TK_STRING, 8'd0,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            phase_next = jbt_pkg::PH_IDLE;
          end else if (b == 8'h5C) begin
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            phase_next = jbt_pkg::PH_ESC;
          end else if (b < 8'h20) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_CTRL_CHAR, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end else begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, b,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
          end
        end
        jbt_pkg::PH_ESC: begin
          case (b)
            8'h22, 8'h5C, 8'h2F: ev = b;
            "b": ev = 8'd8;
            "f": ev = 8'd12;
            "n": ev = 8'd10;
            "r": ev = 8'd13;
            "t": ev = 8'd9;
            default: ev_ok = 1'b0;
          endcase
          if (b == "u") begin
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            hex_acc_next = '0;
            hex_seen_next = '0;
            phase_next = jbt_pkg::PH_HEX;
          end else if (ev_ok) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, ev,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            phase_next = jbt_pkg::PH_STR;
          end else begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_BAD_ESC, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end
        end
        jbt_pkg::PH_HEX: begin
          if (is_dig(b)) d = 4'(b - "0");
          else if (b >= "a" && b <= "f") d = 4'(b - "a" + 8'd10);
          else if (b >= "A" && b <= "F") d = 4'(b - "A" + 8'd10);
          else ev_ok = 1'b0;
          if (!ev_ok) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_BAD_HEX, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end else begin
            hex_acc_next = {hex_acc_next[11:0], d};
            hex_seen_next = hex_seen_next + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            if (hex_seen_next >= 3'd4) begin
              // expand the code unit to UTF-8
              if (hex_acc_next <= 16'h007F) begin
                res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING,
                  hex_acc_next[7:0], 4'd0, lpos(start_line_next), cpos(start_col_next));
                n = n + 3'd1;
              end else if (hex_acc_next <= 16'h07FF) begin
                res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING,
                  {3'b110, hex_acc_next[10:6]}, 4'd0,
                  lpos(start_line_next), cpos(start_col_next));
                n = n + 3'd1;
                res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING,
                  {2'b10, hex_acc_next[5:0]}, 4'd0,
                  lpos(start_line_next), cpos(start_col_next));
                n = n + 3'd1;
              end else begin
                res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING,
                  {4'b1110, hex_acc_next[15:12]}, 4'd0,
                  lpos(start_line_next), cpos(start_col_next));
                n = n + 3'd1;
                res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING,
                  {2'b10, hex_acc_next[11:6]}, 4'd0,
                  lpos(start_line_next), cpos(start_col_next));
                n = n + 3'd1;
                res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING,
                  {2'b10, hex_acc_next[5:0]}, 4'd0,
                  lpos(start_line_next), cpos(start_col_next));
                n = n + 3'd1;
              end
              hex_seen_next = 3'd0;
              phase_next = jbt_pkg::PH_STR;
            end
          end
        end
        jbt_pkg::PH_SIGN, jbt_pkg::PH_DOT, jbt_pkg::PH_ESIGN: begin
          if (is_dig(b)) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_NUMBER, b,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            if (phase_next == jbt_pkg::PH_SIGN)
              phase_next = (b == "0") ? jbt_pkg::PH_ZERO : jbt_pkg::PH_INT;
            else if (phase_next == jbt_pkg::PH_DOT)
              phase_next = jbt_pkg::PH_FRAC;
            else
              phase_next = jbt_pkg::PH_EXP;
          end else begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              (phase_next == jbt_pkg::PH_SIGN) ? jbt_pkg::ER_NUM_DIGIT :
              (phase_next == jbt_pkg::PH_DOT) ? jbt_pkg::ER_FRAC_DIGIT :
              jbt_pkg::ER_EXP_DIGIT, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end
        end
        jbt_pkg::PH_ZERO, jbt_pkg::PH_INT, jbt_pkg::PH_FRAC, jbt_pkg::PH_EXP: begin
          if (((phase_next == jbt_pkg::PH_INT || phase_next == jbt_pkg::PH_FRAC ||
                phase_next == jbt_pkg::PH_EXP) && is_dig(b)) ||
              (phase_next != jbt_pkg::PH_EXP && phase_next != jbt_pkg::PH_FRAC &&
               b == ".") ||
              (phase_next != jbt_pkg::PH_EXP && (b == "e" || b == "E"))) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_NUMBER, b,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            if (is_dig(b)) begin
              // digits keep the phase
            end else if (b == ".") begin
              phase_next = jbt_pkg::PH_DOT;
            end else begin
              phase_next = jbt_pkg::PH_E;
            end
          end else begin
            // close the number, then judge this byte between tokens
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_TOKEN, jbt_pkg::TK_NUMBER, 8'd0,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            phase_next = jbt_pkg::PH_IDLE;
            do_idle = 1'b1;
          end
        end
        jbt_pkg::PH_E: begin
          if (b == "+" || b == "-" || is_dig(b)) begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_NUMBER, b,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            phase_next = is_dig(b) ? jbt_pkg::PH_EXP : jbt_pkg::PH_ESIGN;
          end else begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_EXP_DIGIT, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = jbt_pkg::PH_IDLE;
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        case (b) inside
          8'h20, 8'h09, 8'h0D, 8'h0A: begin
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
          end
          "{": begin tk = jbt_pkg::TK_LBRACE; punct = 1'b1; end
          "}": begin tk = jbt_pkg::TK_RBRACE; punct = 1'b1; end
          "[": begin tk = jbt_pkg::TK_LBRACK; punct = 1'b1; end
          "]": begin tk = jbt_pkg::TK_RBRACK; punct = 1'b1; end
          ",": begin tk = jbt_pkg::TK_COMMA;  punct = 1'b1; end
          ":": begin tk = jbt_pkg::TK_COLON;  punct = 1'b1; end
          8'h22: begin
            start_line_next = line_cnt_next;
            start_col_next = col_cnt_next;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            phase_next = jbt_pkg::PH_STR;
          end
          "t", "f", "n": begin
            start_line_next = line_cnt_next;
            start_col_next = col_cnt_next;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            lit_prog_next = 3'd1;
            phase_next = (b == "t") ? jbt_pkg::PH_LIT_T :
                         (b == "f") ? jbt_pkg::PH_LIT_F : jbt_pkg::PH_LIT_N;
          end
          "-", ["0":"9"]: begin
            start_line_next = line_cnt_next;
            start_col_next = col_cnt_next;
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_CONTENT, jbt_pkg::TK_NUMBER, b,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            line_cnt_next = bump_line(line_cnt_next, b);
            col_cnt_next = bump_col(col_cnt_next, b);
            phase_next = (b == "-") ? jbt_pkg::PH_SIGN :
                         (b == "0") ? jbt_pkg::PH_ZERO : jbt_pkg::PH_INT;
          end
          default: begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_UNEXPECTED, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
            halted_next = 1'b1;
            phase_next = jbt_pkg::PH_IDLE;
          end
        endcase
        if (punct) begin
          res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_TOKEN, tk, 8'd0, 4'd0,
            lpos(line_cnt_next), cpos(col_cnt_next));
          n = n + 3'd1;
          line_cnt_next = bump_line(line_cnt_next, b);
          col_cnt_next = bump_col(col_cnt_next, b);
        end
      end

      // close the document
      if (doc_end && !halted_next) begin
        case (phase_next)
          jbt_pkg::PH_LIT_T, jbt_pkg::PH_LIT_F, jbt_pkg::PH_LIT_N: begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              jbt_pkg::ER_BAD_TRUE + 4'(phase_next - jbt_pkg::PH_LIT_T),
              lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
          end
          jbt_pkg::PH_STR, jbt_pkg::PH_ESC, jbt_pkg::PH_HEX, jbt_pkg::PH_SIGN,
          jbt_pkg::PH_DOT, jbt_pkg::PH_E, jbt_pkg::PH_ESIGN: begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_ERROR, 4'd0, 8'd0,
              (phase_next == jbt_pkg::PH_STR)  ? jbt_pkg::ER_OPEN_STR :
              (phase_next == jbt_pkg::PH_ESC)  ? jbt_pkg::ER_EOF_ESC :
              (phase_next == jbt_pkg::PH_HEX)  ? jbt_pkg::ER_BAD_HEX :
              (phase_next == jbt_pkg::PH_SIGN) ? jbt_pkg::ER_NUM_DIGIT :
              (phase_next == jbt_pkg::PH_DOT)  ? jbt_pkg::ER_FRAC_DIGIT :
              jbt_pkg::ER_EXP_DIGIT, lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
          end
          jbt_pkg::PH_ZERO, jbt_pkg::PH_INT, jbt_pkg::PH_FRAC, jbt_pkg::PH_EXP: begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_TOKEN, jbt_pkg::TK_NUMBER, 8'd0,
              4'd0, lpos(start_line_next), cpos(start_col_next));
            n = n + 3'd1;
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_END, 4'd0, 8'd0, 4'd0,
              lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
          end
          default: begin
            res[n[1:0]] = jbt_pkg::mk_res(jbt_pkg::RK_END, 4'd0, 8'd0, 4'd0,
              lpos(line_cnt_next), cpos(col_cnt_next));
            n = n + 3'd1;
          end
        endcase
        halted_next = 1'b1;
        phase_next = jbt_pkg::PH_IDLE;
      end
    end
    res_cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jbt_pkg::PH_IDLE;
      line_cnt <= LINE_BITS'(1);
      col_cnt <= COLUMN_BITS'(1);
      start_line <= LINE_BITS'(1);
      start_col <= COLUMN_BITS'(1);
      hex_acc <= '0;
      hex_seen <= '0;
      lit_prog <= '0;
      halted <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      line_cnt <= line_cnt_next;
      col_cnt <= col_cnt_next;
      start_line <= start_line_next;
      start_col <= start_col_next;
      hex_acc <= hex_acc_next;
      hex_seen <= hex_seen_next;
      lit_prog <= lit_prog_next;
      halted <= halted_next;
    end
  end

endmodule

// ===== rtl/core/jbt_out_buf.sv =====
// ----------------------------------------------------------------------------
// jbt_out_buf
// Result register: holds one byte's results, sends one a cycle unless stalled.
// ----------------------------------------------------------------------------
module jbt_out_buf (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  jbt_pkg::res_t [jbt_pkg::MAX_RES-1:0] load_res,
  input  logic [2:0]                           load_cnt,
  output logic                                 free,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           result_kind,
  output logic [3:0]                           token_kind,
  output logic [7:0]                           content_byte,
  output logic [3:0]                           error_code,
  output logic [jbt_pkg::POS_W-1:0]            pos_line,
  output logic [jbt_pkg::POS_W-1:0]            pos_column,
  output logic                                 last_of_item
);

  jbt_pkg::res_t [jbt_pkg::MAX_RES-1:0] ent;
  logic [1:0]    rd_ptr;
  logic [2:0]    remain;
  jbt_pkg::res_t cur;
  logic          take;

  assign out_valid = (remain != 3'd0);
  assign take = out_valid && !out_stall;
  assign free = (remain == 3'd0) || (remain == 3'd1 && !out_stall);
  assign cur = ent[rd_ptr];

  assign result_kind  = cur.kind;
  assign token_kind   = cur.tok;
  assign content_byte = cur.data;
  assign error_code   = cur.err;
  assign pos_line     = cur.line;
  assign pos_column   = cur.col;
  assign last_of_item = (remain == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
      rd_ptr <= 2'd0;
    end else if (load) begin
      remain <= load_cnt;
      rd_ptr <= 2'd0;
    end else if (take) begin
      remain <= remain - 3'd1;
      rd_ptr <= rd_ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= load_res;
    end
  end

endmodule

// ===== rtl/core/json_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// JSON lexer: one byte per transaction; token, content, error, end results out.
// ----------------------------------------------------------------------------
// Path: a byte waits in the input register until the result buffer is free;
// the lexer step then loads its results into the buffer, which presents them.
// Throughput: one byte per cycle while no byte gives more than one result and
// out_stall is low; extra results hold the input until the port has sent them.
// Reset: rst clears the lexer to between tokens, counters to one, halt cleared.
module json_byte_tokenizer #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        doc_start,
  input  logic        doc_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [3:0]  token_kind,
  output logic [7:0]  content_byte,
  output logic [3:0]  error_code,
  output logic [23:0] pos_line,
  output logic [23:0] pos_column,
  output logic        last_of_item
);

  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_start;
  logic       ir_end;
  logic       buf_free;
  logic       advance;
  logic       accept;
  jbt_pkg::res_t [jbt_pkg::MAX_RES-1:0] step_res;
  logic [2:0] step_cnt;

  assign advance  = ir_valid && buf_free;
  assign in_stall = ir_valid && !buf_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (accept) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_byte  <= text_byte;
      ir_start <= doc_start;
      ir_end   <= doc_end;
    end
  end

  jbt_lexer #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .text_byte (ir_byte),
    .doc_start (ir_start),
    .doc_end   (ir_end),
    .res       (step_res),
    .res_cnt   (step_cnt)
  );

  jbt_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && step_cnt != 3'd0),
    .load_res     (step_res),
    .load_cnt     (step_cnt),
    .free         (buf_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .token_kind   (token_kind),
    .content_byte (content_byte),
    .error_code   (error_code),
    .pos_line     (pos_line),
    .pos_column   (pos_column),
    .last_of_item (last_of_item)
  );

endmodule

// ===== rtl/core/jbt_checker.sv =====
// ----------------------------------------------------------------------------
// jbt_checker
// Port-level checks of the tokenizer result stream.
// ----------------------------------------------------------------------------
module jbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [3:0]  token_kind,
  input logic        last_of_item
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
    $stable(token_kind) && $stable(last_of_item))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == jbt_pkg::RK_ERROR |-> last_of_item)
    else $error("error result not last of its byte");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == jbt_pkg::RK_END |-> last_of_item)
    else $error("end token not last of its byte");

  a_content_tok: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == jbt_pkg::RK_CONTENT |->
    token_kind == jbt_pkg::TK_STRING || token_kind == jbt_pkg::TK_NUMBER)
    else $error("content byte outside string or number");

  // the input only backs up while the result side is busy
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stall with no result pending");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_kind  (result_kind),
  .token_kind   (token_kind),
  .last_of_item (last_of_item)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// JSON byte tokenizer testbench
// Drives JSON text bytes with random gaps and back-pressure, predicts every
// token, content byte, error and end result, and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  tok;
    logic [7:0]  data;
    logic [3:0]  err;
    logic [23:0] line;
    logic [23:0] col;
    logic        last;
  } lex_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'd0;
  logic        doc_start = 1'b0;
  logic        doc_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [3:0]  token_kind;
  logic [7:0]  content_byte;
  logic [3:0]  error_code;
  logic [23:0] pos_line;
  logic [23:0] pos_column;
  logic        last_of_item;

  json_byte_tokenizer DUT (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [3:0]  phase;
  logic [23:0] cur_line, cur_col, tok_line, tok_col;
  logic [15:0] hex_val;
  logic [2:0]  hex_cnt, lit_pos;
  logic        stopped;
  lex_result_t expected_results[$];
  lex_result_t step_results[$];

  int  mismatch_count = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s: got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic void lexer_clear();
    phase = jbt_pkg::PH_IDLE; cur_line = 24'd1; cur_col = 24'd1;
    tok_line = 24'd1; tok_col = 24'd1;
    hex_val = 16'd0; hex_cnt = 3'd0; lit_pos = 3'd0; stopped = 1'b0;
  endfunction

  function automatic void push(input logic [1:0] k, input logic [3:0] t, input logic [7:0] d,
                               input logic [3:0] e, input logic [23:0] l, input logic [23:0] c);
    lex_result_t r;
    r.kind = k; r.tok = t; r.data = d; r.err = e; r.line = l; r.col = c; r.last = 1'b0;
    if (step_results.size() < jbt_pkg::MAX_RES)
      step_results.insert(step_results.size(), r);
  endfunction

  function automatic void halt_with(input logic [3:0] e, input logic [23:0] l,
                                    input logic [23:0] c);
    push(jbt_pkg::RK_ERROR, 4'd0, 8'd0, e, l, c);
    stopped = 1'b1;
    phase = jbt_pkg::PH_IDLE;
  endfunction

  function automatic void advance(input logic [7:0] b);
    if (b == 8'h0A) begin
      if (cur_line != 24'hFFFFFF) cur_line++;
      cur_col = 24'd1;
    end else if (cur_col != 24'hFFFFFF) begin
      cur_col++;
    end
  endfunction

  function automatic bit is_dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void take_num(input logic [7:0] b, input logic [3:0] nxt);
    push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_NUMBER, b, 4'd0, tok_line, tok_col);
    advance(b);
    phase = nxt;
  endfunction

  function automatic void between_tokens(input logic [7:0] b);
    logic [3:0] t;
    bit punct;
    punct = 1'b1;
    t = jbt_pkg::TK_LBRACE;
    case (b)
      " ", "\t", 8'h0D, 8'h0A: begin advance(b); return; end
      "{": t = jbt_pkg::TK_LBRACE;
      "}": t = jbt_pkg::TK_RBRACE;
      "[": t = jbt_pkg::TK_LBRACK;
      "]": t = jbt_pkg::TK_RBRACK;
      ",": t = jbt_pkg::TK_COMMA;
      ":": t = jbt_pkg::TK_COLON;
      "\"": begin
        tok_line = cur_line; tok_col = cur_col; advance(b); phase = jbt_pkg::PH_STR;
        return;
      end
      "t", "f", "n": begin
        tok_line = cur_line; tok_col = cur_col; advance(b); lit_pos = 3'd1;
        phase = (b == "t") ? jbt_pkg::PH_LIT_T :
                (b == "f") ? jbt_pkg::PH_LIT_F : jbt_pkg::PH_LIT_N;
        return;
      end
      default: punct = 1'b0;
    endcase
    if (punct) begin
      push(jbt_pkg::RK_TOKEN, t, 8'd0, 4'd0, cur_line, cur_col);
      advance(b);
    end else if (b == "-" || is_dig(b)) begin
      tok_line = cur_line; tok_col = cur_col;
      take_num(b, b == "-" ? jbt_pkg::PH_SIGN :
                  (b == "0" ? jbt_pkg::PH_ZERO : jbt_pkg::PH_INT));
    end else begin
      halt_with(jbt_pkg::ER_UNEXPECTED, cur_line, cur_col);
    end
  endfunction

  function automatic void close_num(input logic [7:0] b);
    push(jbt_pkg::RK_TOKEN, jbt_pkg::TK_NUMBER, 8'd0, 4'd0, tok_line, tok_col);
    phase = jbt_pkg::PH_IDLE;
    between_tokens(b);
  endfunction

  function automatic void lex_byte(input logic [7:0] b);
    logic [1:0] idx;
    logic [3:0] d;
    logic [7:0] v;
    case (phase)
      jbt_pkg::PH_LIT_T, jbt_pkg::PH_LIT_F, jbt_pkg::PH_LIT_N: begin
        idx = 2'(phase - jbt_pkg::PH_LIT_T);
        if (lit_pos < jbt_pkg::lit_len(idx) && b == jbt_pkg::lit_char(idx, lit_pos)) begin
          advance(b);
          lit_pos++;
          if (lit_pos >= jbt_pkg::lit_len(idx)) begin
            push(jbt_pkg::RK_TOKEN, jbt_pkg::TK_TRUE + 4'(idx), 8'd0, 4'd0,
                 tok_line, tok_col);
            lit_pos = 3'd0; phase = jbt_pkg::PH_IDLE;
          end
        end else begin
          halt_with(jbt_pkg::ER_BAD_TRUE + 4'(idx), tok_line, tok_col);
        end
      end
      jbt_pkg::PH_STR: begin
        if (b == "\"") begin
          push(jbt_pkg::RK_TOKEN, jbt_pkg::TK_STRING, 8'd0, 4'd0, tok_line, tok_col);
          advance(b); phase = jbt_pkg::PH_IDLE;
        end else if (b == "\\") begin
          advance(b); phase = jbt_pkg::PH_ESC;
        end else if (b < 8'h20) begin
          halt_with(jbt_pkg::ER_CTRL_CHAR, cur_line, cur_col);
        end else begin
          push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, b, 4'd0, tok_line, tok_col);
          advance(b);
        end
      end
      jbt_pkg::PH_ESC: begin
        case (b)
          "\"", "\\", "/": v = b;
          "b": v = 8'd8;
          "f": v = 8'd12;
          "n": v = 8'd10;
          "r": v = 8'd13;
          "t": v = 8'd9;
          "u": v = 8'hFF;
          default: v = 8'h00;
        endcase
        if (b == "u") begin
          advance(b); hex_val = 16'd0; hex_cnt = 3'd0; phase = jbt_pkg::PH_HEX;
        end else if (v == 8'h00) begin
          halt_with(jbt_pkg::ER_BAD_ESC, cur_line, cur_col);
        end else begin
          push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, v, 4'd0, tok_line, tok_col);
          advance(b); phase = jbt_pkg::PH_STR;
        end
      end
      jbt_pkg::PH_HEX: begin
        if (is_dig(b)) d = 4'(b - "0");
        else if (b >= "a" && b <= "f") d = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") d = 4'(b - "A" + 8'd10);
        else begin halt_with(jbt_pkg::ER_BAD_HEX, cur_line, cur_col); return; end
        hex_val = {hex_val[11:0], d};
        hex_cnt++;
        advance(b);
        if (hex_cnt >= 3'd4) begin
          if (hex_val <= 16'h7F) begin
            push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, hex_val[7:0], 4'd0,
                 tok_line, tok_col);
          end else if (hex_val <= 16'h7FF) begin
            push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, {3'b110, hex_val[10:6]}, 4'd0,
                 tok_line, tok_col);
            push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, {2'b10, hex_val[5:0]}, 4'd0,
                 tok_line, tok_col);
          end else begin
            push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, {4'b1110, hex_val[15:12]}, 4'd0,
                 tok_line, tok_col);
            push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, {2'b10, hex_val[11:6]}, 4'd0,
                 tok_line, tok_col);
            push(jbt_pkg::RK_CONTENT, jbt_pkg::TK_STRING, {2'b10, hex_val[5:0]}, 4'd0,
                 tok_line, tok_col);
          end
          hex_cnt = 3'd0; phase = jbt_pkg::PH_STR;
        end
      end
      jbt_pkg::PH_SIGN:
        if (is_dig(b)) take_num(b, b == "0" ? jbt_pkg::PH_ZERO : jbt_pkg::PH_INT);
        else halt_with(jbt_pkg::ER_NUM_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_ZERO, jbt_pkg::PH_INT:
        if (phase == jbt_pkg::PH_INT && is_dig(b)) take_num(b, jbt_pkg::PH_INT);
        else if (b == ".") take_num(b, jbt_pkg::PH_DOT);
        else if (b == "e" || b == "E") take_num(b, jbt_pkg::PH_E);
        else close_num(b);
      jbt_pkg::PH_DOT:
        if (is_dig(b)) take_num(b, jbt_pkg::PH_FRAC);
        else halt_with(jbt_pkg::ER_FRAC_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_FRAC:
        if (is_dig(b)) take_num(b, jbt_pkg::PH_FRAC);
        else if (b == "e" || b == "E") take_num(b, jbt_pkg::PH_E);
        else close_num(b);
      jbt_pkg::PH_E:
        if (b == "+" || b == "-") take_num(b, jbt_pkg::PH_ESIGN);
        else if (is_dig(b)) take_num(b, jbt_pkg::PH_EXP);
        else halt_with(jbt_pkg::ER_EXP_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_ESIGN:
        if (is_dig(b)) take_num(b, jbt_pkg::PH_EXP);
        else halt_with(jbt_pkg::ER_EXP_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_EXP:
        if (is_dig(b)) take_num(b, jbt_pkg::PH_EXP);
        else close_num(b);
      default: begin
        phase = jbt_pkg::PH_IDLE;
        between_tokens(b);
      end
    endcase
  endfunction

  function automatic void close_document();
    case (phase)
      jbt_pkg::PH_LIT_T, jbt_pkg::PH_LIT_F, jbt_pkg::PH_LIT_N:
        halt_with(jbt_pkg::ER_BAD_TRUE + 4'(phase - jbt_pkg::PH_LIT_T), tok_line, tok_col);
      jbt_pkg::PH_STR: halt_with(jbt_pkg::ER_OPEN_STR, cur_line, cur_col);
      jbt_pkg::PH_ESC: halt_with(jbt_pkg::ER_EOF_ESC, cur_line, cur_col);
      jbt_pkg::PH_HEX: halt_with(jbt_pkg::ER_BAD_HEX, cur_line, cur_col);
      jbt_pkg::PH_SIGN: halt_with(jbt_pkg::ER_NUM_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_DOT: halt_with(jbt_pkg::ER_FRAC_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_E, jbt_pkg::PH_ESIGN: halt_with(jbt_pkg::ER_EXP_DIGIT, cur_line, cur_col);
      jbt_pkg::PH_ZERO, jbt_pkg::PH_INT, jbt_pkg::PH_FRAC, jbt_pkg::PH_EXP: begin
        push(jbt_pkg::RK_TOKEN, jbt_pkg::TK_NUMBER, 8'd0, 4'd0, tok_line, tok_col);
        push(jbt_pkg::RK_END, 4'd0, 8'd0, 4'd0, cur_line, cur_col);
      end
      default: push(jbt_pkg::RK_END, 4'd0, 8'd0, 4'd0, cur_line, cur_col);
    endcase
    stopped = 1'b1;
    phase = jbt_pkg::PH_IDLE;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic ds, input logic de);
    step_results.delete();
    if (ds) lexer_clear();
    if (stopped) return;
    lex_byte(b);
    if (de && !stopped) close_document();
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) expected_results.insert(expected_results.size(), step_results[i]);
  endfunction

  // send one byte; gaps before it unless quiet
  task automatic send_byte(input logic [7:0] b, input logic ds = 1'b0, input logic de = 1'b0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    text_byte <= b; doc_start <= ds; doc_end <= de; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, ds, de);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit fresh = 1'b1, input bit close = 1'b1);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fresh && i == 0, close && i == s.len() - 1);
  endtask

  // result checker
  always @(posedge clk) begin
    lex_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("result with none expected", 32'(result_kind), 32'd0);
      end else begin
        w = expected_results.pop_front();
        if (result_kind !== w.kind) report("result_kind", 32'(result_kind), 32'(w.kind));
        if (token_kind !== w.tok) report("token_kind", 32'(token_kind), 32'(w.tok));
        if (content_byte !== w.data) report("content_byte", 32'(content_byte), 32'(w.data));
        if (error_code !== w.err) report("error_code", 32'(error_code), 32'(w.err));
        if (pos_line !== w.line) report("pos_line", 32'(pos_line), 32'(w.line));
        if (pos_column !== w.col) report("pos_column", 32'(pos_column), 32'(w.col));
        if (last_of_item !== w.last) report("last_of_item", 32'(last_of_item), 32'(w.last));
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_punctuation_and_literals();
    send_text("{ \"k\" : [true,false,null] }\n", 1'b0, 1'b1);
    send_text("tru");
    send_text("fals");
    send_text("nul");
    send_text("trux");
    send_text("truetrue");
  endtask

  task automatic test_strings();
    send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\\u0041\\u00e9\\uFFFF\\u07Ff\\u0800\"");
    send_text({"\"", 8'h80, 8'hFF, 8'h20, "\""});
    send_text({"\"x", 8'h1F, "\""});
    send_text("\"\\q\"");
    send_text("\"\\u12g4\"");
    send_text("\"open");
    send_text("\"\\");
    send_text("\"\\u12");
  endtask

  task automatic test_numbers();
    send_text("01 -0.5e+10 12E-3 7e9,-12.25");
    send_text("-");
    send_text("-x");
    send_text("1.");
    send_text("1.x");
    send_text("1e");
    send_text("1e+");
    send_text("1e+q");
    send_text("1.5 ");
    send_text("@");
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(" ", 1'b0, 1'b0);   // halted: no results
    send_text("\n\n\t\r5 ");
  endtask

  task automatic test_idle_pause();
    send_text("[1,2]");
    drain();
    send_text("{\"z\":3}");
  endtask

  function automatic string rand_token();
    string pool[16];
    pool = '{"{", "}", "[", "]", ",", ":", " ", "\n", "true", "false", "null",
             "\"ab\\n\\u00C4\"", "-12.5e3", "0", "\"\\u20AC x\"", "42"};
    return pool[$urandom_range(0, 15)];
  endfunction

  task automatic test_random_documents();
    int sent;
    string doc;
    sent = 0;
    while (sent < 100) begin
      doc = "";
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8))
          doc = $sformatf("%s%c", doc, 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) doc = {doc, rand_token()};
        if ($urandom_range(0, 5) == 0)
          doc = $sformatf("%s%c", doc, 8'($urandom_range(1, 255)));
      end
      if (sent > 60) quiet = 1'b1;
      send_text(doc, 1'b1, $urandom_range(0, 7) != 0);
      sent += doc.len();
    end
  endtask

  initial begin
    lexer_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_punctuation_and_literals();
    test_strings();
    test_numbers();
    test_idle_pause();
    test_random_documents();
    drain();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/jbt_pkg.sv
rtl/core/jbt_lexer.sv
rtl/core/jbt_out_buf.sv
rtl/core/json_byte_tokenizer.sv
rtl/core/jbt_checker.sv
dv/testbench.sv
